// File: src/knn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_pkg: shared constants and types
// Sizes, operation codes and the cell-to-cell beat of the sorted neighbor chain.
// ----------------------------------------------------------------------------
package knn_pkg;
	localparam int ENTRIES  = 256;
	localparam int FEATURES = 8;
	localparam int K_MAX    = 16;
	localparam int EW = $clog2(ENTRIES);
	localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int KW = $clog2(K_MAX + 1);

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_REF    = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] REG_NEIGHBOURS = 2'd0;
	localparam logic [1:0] REG_ENTRIES    = 2'd1;
	localparam logic [1:0] REG_THRESHOLD  = 2'd2;

	// beat handed down the chain: a candidate and its class
	typedef struct packed {
		logic        vld;
		logic [63:0] dsum;
		logic [7:0]  cls;
	} cand_t;
endpackage

// File: src/knn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_cell: one slot of the sorted neighbor chain
// Keeps the better of its own entry and the incoming beat and passes the other on while enabled.
// ----------------------------------------------------------------------------
module knn_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clr,
	input  logic           en,
	input  knn_pkg::cand_t din,
	output knn_pkg::cand_t dout,
	output knn_pkg::cand_t slot
);
	import knn_pkg::*;
	cand_t slot_q;
	logic  take;

	// strict less keeps the earlier entry first on ties
	assign take = din.vld && (!slot_q.vld || din.dsum < slot_q.dsum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			dout   <= '0;
		end else if (clr) begin
			slot_q <= '0;
			dout   <= '0;
		end else if (en) begin
			if (take) begin
				slot_q <= din;
				dout   <= slot_q;
			end else begin
				dout <= din;
			end
		end else begin
			dout <= '0;
		end
	end
	assign slot = slot_q;
endmodule

// File: src/knn_weighted_euclid_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_weighted_euclid_classifier: weighted Euclidean k-nearest-neighbor
// Reference store, weight and query registers, distance unit, neighbor chain.
// ----------------------------------------------------------------------------
// Load items are accepted whenever busy is low. A query item with last set
// starts a scan that reads one (entry, feature) word of the reference store per
// cycle through a three-stage square-and-weight pipeline; busy stays high until
// the result is out. Sorted candidates ripple down a chain of K_MAX cells, one
// hop per cycle; the vote then walks the n kept slots pairwise, where n is the
// smaller of k and entry_count, and is skipped when the result is unknown.
// done is high for a single cycle as the result appears and cannot be stalled.
module knn_weighted_euclid_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  entry_index,
	input  logic [2:0]  feature_index,
	input  logic signed [31:0] value,
	input  logic [7:0]  class_id,
	input  logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic [7:0]  class_id_res,
	output logic        unknown,
	output logic [63:0] best_distance,
	output logic [4:0]  vote_count
);
	import knn_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_FLSH = 3'd2;
	localparam logic [2:0] ST_VOTE = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [4:0]  neigh_q;
	logic [8:0]  ecnt_q;
	logic [63:0] thr_q;
	logic [2:0]  state_q;

	logic [31:0] feat_mem [ENTRIES*FEATURES];
	logic [7:0]  cls_mem [ENTRIES];
	logic [31:0] wgt_q [FEATURES];
	logic [31:0] qry_q [FEATURES];

	logic        acc;
	assign acc  = start && !busy;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neigh_q <= 5'd1;
			ecnt_q  <= 9'd1;
			thr_q   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEIGHBOURS: neigh_q <= cfg_data[4:0];
				REG_ENTRIES:    ecnt_q  <= cfg_data[8:0];
				REG_THRESHOLD:  thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stores
	always_ff @(posedge clk) begin
		if (acc && operation == OP_REF) begin
			feat_mem[{entry_index, feature_index}] <= value;
			cls_mem[entry_index] <= class_id;
		end
		if (acc && operation == OP_WEIGHT) wgt_q[feature_index] <= value;
		if (acc && operation == OP_QUERY)  qry_q[feature_index] <= value;
	end

	// scan counters
	logic [8:0]    ent_q;
	logic [FW-1:0] fi_q;
	logic [4:0]    k_eff;
	logic [8:0]    cnt_eff;
	logic [7:0]    flush_q;
	assign k_eff   = (neigh_q == 5'd0) ? 5'd1 : (neigh_q > 5'(K_MAX)) ? 5'(K_MAX) : neigh_q;
	assign cnt_eff = (ecnt_q > 9'(ENTRIES)) ? 9'(ENTRIES) : ecnt_q;

	// stage 1: memory read
	logic          v_s1, lf_s1;
	logic [FW-1:0] f_s1;
	logic [31:0]   rf_s1;
	logic [7:0]    rc_s1;
	logic          rd;
	assign rd = (state_q == ST_SCAN) && (ent_q < cnt_eff);
	always_ff @(posedge clk) begin
		rf_s1 <= feat_mem[{ent_q[EW-1:0], fi_q}];
		rc_s1 <= cls_mem[ent_q[EW-1:0]];
		f_s1  <= fi_q;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; lf_s1 <= 1'b0;
		end else begin
			v_s1 <= rd; lf_s1 <= (fi_q == FW'(FEATURES-1));
		end
	end

	// stage 2: square of the difference
	logic          v_s2, lf_s2;
	logic [63:0]   sq_s2;
	logic [31:0]   w_s2;
	logic [7:0]    rc_s2;
	logic signed [32:0] dif;
	logic [31:0]   mag;
	assign dif = 33'($signed(qry_q[f_s1])) - 33'($signed(rf_s1));
	assign mag = dif[32] ? 32'(-dif) : dif[31:0];
	always_ff @(posedge clk) begin
		sq_s2 <= mag * mag;
		w_s2  <= wgt_q[f_s1];
		rc_s2 <= rc_s1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0; lf_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1; lf_s2 <= lf_s1;
		end
	end

	// stage 3: weight products
	logic        v_s3, lf_s3;
	logic [63:0] hi_s3, lo_s3;
	logic [7:0]  rc_s3;
	always_ff @(posedge clk) begin
		hi_s3 <= sq_s2[63:32] * w_s2;
		lo_s3 <= sq_s2[31:0] * w_s2;
		rc_s3 <= rc_s2;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0; lf_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2; lf_s3 <= lf_s2;
		end
	end

	// accumulate with saturation
	logic [64:0] t1, t2;
	logic [63:0] term, acc_q, nsum;
	assign t1   = {1'b0, hi_s3} + {33'b0, lo_s3[63:32]};
	assign term = t1[64] ? '1 : t1[63:0];
	assign t2   = {1'b0, acc_q} + {1'b0, term};
	assign nsum = t2[64] ? '1 : t2[63:0];

	cand_t head_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			head_q <= '0;
		end else begin
			head_q <= '0;
			if (v_s3) begin
				if (lf_s3) begin
					acc_q  <= '0;
					head_q <= '{vld: 1'b1, dsum: nsum, cls: rc_s3};
				end else begin
					acc_q <= nsum;
				end
			end
		end
	end

	// neighbor chain
	cand_t chain [K_MAX+1];
	cand_t slots [K_MAX];
	logic  clr;
	assign clr = acc && operation == OP_QUERY && last;
	assign chain[0] = head_q;
	for (genvar g = 0; g < K_MAX; g++) begin : g_cell
		knn_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clr(clr), .en(5'(g) < k_eff),
			.din(chain[g]), .dout(chain[g+1]), .slot(slots[g])
		);
	end

	// vote: for slot i count matches in all slots, one j per cycle
	logic [KW-1:0] vi_q, vj_q, cnt_q, bn_q, c0_q;
	logic [7:0]    bc_q;
	logic [KW-1:0] nfill;
	logic [KW:0]   nf;
	always_comb begin
		nf = '0;
		for (int i = 0; i < K_MAX; i++) nf = nf + (KW+1)'(slots[i].vld);
	end
	assign nfill = nf[KW-1:0];

	logic [KW-1:0] cnt_n;
	assign cnt_n = cnt_q + KW'(slots[vj_q[KW-2:0]].cls == slots[vi_q[KW-2:0]].cls);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q <= '0; fi_q <= '0; flush_q <= '0;
			vi_q <= '0; vj_q <= '0; cnt_q <= '0; bn_q <= '0; c0_q <= '0; bc_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (clr) begin
					state_q <= ST_SCAN; ent_q <= '0; fi_q <= '0;
				end
				ST_SCAN: begin
					if (ent_q >= cnt_eff) begin
						state_q <= ST_FLSH; flush_q <= '0;
					end else if (fi_q == FW'(FEATURES-1)) begin
						fi_q <= '0; ent_q <= ent_q + 9'd1;
					end else begin
						fi_q <= fi_q + FW'(1);
					end
				end
				ST_FLSH: begin
					flush_q <= flush_q + 8'd1;
					if (flush_q == 8'(K_MAX + 6)) begin
						state_q <= ST_VOTE;
						vi_q <= '0; vj_q <= '0; cnt_q <= '0; bn_q <= '0; c0_q <= '0;
						bc_q <= slots[0].cls;
					end
				end
				ST_VOTE: begin
					if (nfill == '0 || slots[0].dsum > thr_q || vi_q >= nfill) begin
						state_q <= ST_OUT;
					end else if (vj_q == nfill - KW'(1)) begin
						vj_q <= '0; cnt_q <= '0; vi_q <= vi_q + KW'(1);
						if (vi_q == '0) begin
							bn_q <= cnt_n; c0_q <= cnt_n;
						end else if (cnt_n > bn_q || (cnt_n == bn_q && cnt_n > c0_q
							&& slots[vi_q[KW-2:0]].cls < bc_q)) begin
							bn_q <= cnt_n; bc_q <= slots[vi_q[KW-2:0]].cls;
						end
					end else begin
						vj_q <= vj_q + KW'(1); cnt_q <= cnt_n;
					end
				end
				ST_OUT: begin
					state_q <= ST_IDLE; done <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic unk;
	assign unk = (nfill == '0) || (slots[0].dsum > thr_q);
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			best_distance <= slots[0].vld ? slots[0].dsum : '1;
			unknown       <= unk;
			class_id_res  <= unk ? 8'd0 : bc_q;
			vote_count    <= unk ? 5'd0 : 5'(bn_q);
		end
	end

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> busy) else $error("scan did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(slots[1].vld |-> slots[0].vld && slots[0].dsum <= slots[1].dsum))
		else $error("chain out of order");
endmodule
